[hw/rtl/pixel_neighbor_affinity_weights_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the affinity weight block
// Same-cycle and next-cycle implication checks on the block clock.
// ----------------------------------------------------------------------------
`ifndef PIXEL_NEIGHBOR_AFFINITY_WEIGHTS_TOP_ASSERT_SVH
`define PIXEL_NEIGHBOR_AFFINITY_WEIGHTS_TOP_ASSERT_SVH

`define PNAW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define PNAW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/pnaw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnaw_pkg
// Types, constants and exp tables for the affinity weight block.
// ----------------------------------------------------------------------------
package pnaw_pkg;

  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int IDX_W      = 20;
  localparam int WGT_W      = 16;
  localparam int DIM_CFG_W  = 11;
  localparam int SIG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_AW    = 3;
  localparam int OFIFO_CW    = 4;
  localparam int NDIR        = 4;
  localparam int WU_STAGES   = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH, REG_HEIGHT, REG_INV_SIG_COLOR, REG_INV_SIG_EDGE
  } cfg_reg_t;

  typedef enum logic [1:0] {DIR_DOWN, DIR_UP, DIR_RIGHT, DIR_LEFT} dir_t;

  typedef enum logic [1:0] {RD_CENTER, RD_SIDE, RD_LEFT} rd_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_WAIT, ST_ISSUE
  } state_t;

  typedef struct packed {
    logic    accept;
    rd_sel_t rd_sel;
    logic    cap0;
    logic    cap1;
    logic    cap2;
    logic    wr;
    logic    issue;
    dir_t    dir;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic room;
  } dp_status_t;

  typedef struct packed {
    logic [IDX_W-1:0] cidx;
    logic [IDX_W-1:0] nidx;
    dir_t             dir;
    logic             last;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [WGT_W-1:0] weight;
  } res_t;

  function automatic logic [24:0] exp_int(input logic [3:0] k);
    logic [24:0] v;
    case (k)
      4'd0:  v = 25'd16777216;
      4'd1:  v = 25'd6171993;
      4'd2:  v = 25'd2270549;
      4'd3:  v = 25'd835288;
      4'd4:  v = 25'd307285;
      4'd5:  v = 25'd113044;
      4'd6:  v = 25'd41587;
      4'd7:  v = 25'd15299;
      4'd8:  v = 25'd5628;
      4'd9:  v = 25'd2070;
      4'd10: v = 25'd762;
      4'd11: v = 25'd280;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

  function automatic logic [24:0] exp_frac(input logic [3:0] j);
    logic [24:0] v;
    case (j)
      4'd0:  v = 25'd16777216;
      4'd1:  v = 25'd15760736;
      4'd2:  v = 25'd14805841;
      4'd3:  v = 25'd13908801;
      4'd4:  v = 25'd13066109;
      4'd5:  v = 25'd12274473;
      4'd6:  v = 25'd11530801;
      4'd7:  v = 25'd10832185;
      4'd8:  v = 25'd10175896;
      4'd9:  v = 25'd9559370;
      4'd10: v = 25'd8980197;
      4'd11: v = 25'd8436114;
      4'd12: v = 25'd7924996;
      4'd13: v = 25'd7444844;
      4'd14: v = 25'd6993783;
      default: v = 25'd6570052;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/pnaw_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnaw channel interfaces
// Valid/ready channels for pixel items, weight items and register writes.
// ----------------------------------------------------------------------------
interface pnaw_in_if import pnaw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            mode;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] edge_value;
  modport source (output valid, mode, red, green, blue, edge_value, input ready);
  modport sink   (input valid, mode, red, green, blue, edge_value, output ready);
endinterface

interface pnaw_out_if import pnaw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] center_index;
  logic [IDX_W-1:0] neighbor_index;
  logic [1:0]       direction;
  logic [WGT_W-1:0] weight;
  logic             last;
  modport source (output valid, center_index, neighbor_index, direction, weight, last,
                  input ready);
  modport sink   (input valid, center_index, neighbor_index, direction, weight, last,
                  output ready);
endinterface

interface pnaw_cfg_if import pnaw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/pixel_neighbor_affinity_weights_top.sv]
`timescale 1ns / 1ps
// Sequence: an item that is not ignored is accepted in ST_IDLE, the line buffers are read
// in ST_RD0 to ST_RD3 (one read port each), ST_WAIT holds until the output queue has room
// for four weights and ST_ISSUE steps through the directions; only then is a new item taken.
// Ignored items are dropped in ST_IDLE. All directions share one weight pipeline (9 stages).
// Reset: synchronous active low; counters and registers to defaults, buffers not cleared.
// ----------------------------------------------------------------------------
// pixel_neighbor_affinity_weights_top
// Four-neighbor color affinity weights from a raster pixel stream.
// ----------------------------------------------------------------------------
module pixel_neighbor_affinity_weights_top import pnaw_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input logic        clk,
  input logic        rst_n,
  pnaw_in_if.sink    in_chan,
  pnaw_out_if.source out_chan,
  pnaw_cfg_if.sink   cfg_chan
);

  dp_cmd_t            cmd;
  dp_status_t         st;
  logic               skip, room, fifo_full;
  logic [SIG_W-1:0]   isc, ise;
  logic               wop_valid, wres_valid;
  logic [COLOR_W-1:0] wop_ca, wop_cb;
  logic [CH_W-1:0]    wop_edge;
  meta_t              wop_meta;
  res_t               wres, ores;

  assign st.skip        = skip;
  assign st.room        = room;
  assign cfg_chan.ready = 1'b1;

  pnaw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .st       (st),
    .cmd      (cmd)
  );

  pnaw_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .skip          (skip),
    .in_mode       (in_chan.mode),
    .in_red        (in_chan.red),
    .in_green      (in_chan.green),
    .in_blue       (in_chan.blue),
    .in_edge       (in_chan.edge_value),
    .cfg_we        (cfg_chan.valid),
    .cfg_idx       (cfg_chan.index),
    .cfg_wdata     (cfg_chan.data),
    .inv_sig_color (isc),
    .inv_sig_edge  (ise),
    .op_valid      (wop_valid),
    .op_ca         (wop_ca),
    .op_cb         (wop_cb),
    .op_edge       (wop_edge),
    .op_meta       (wop_meta)
  );

  pnaw_wunit u_wunit (
    .clk           (clk),
    .rst_n         (rst_n),
    .inv_sig_color (isc),
    .inv_sig_edge  (ise),
    .op_valid      (wop_valid),
    .op_ca         (wop_ca),
    .op_cb         (wop_cb),
    .op_edge       (wop_edge),
    .op_meta       (wop_meta),
    .res_valid     (wres_valid),
    .res           (wres)
  );

  pnaw_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (wop_valid),
    .push      (wres_valid),
    .push_data (wres),
    .pop_valid (out_chan.valid),
    .pop_ready (out_chan.ready),
    .pop_data  (ores),
    .room      (room),
    .full      (fifo_full)
  );

  assign out_chan.center_index   = ores.meta.cidx;
  assign out_chan.neighbor_index = ores.meta.nidx;
  assign out_chan.direction      = ores.meta.dir;
  assign out_chan.weight         = ores.weight;
  assign out_chan.last           = ores.meta.last;

`include "pixel_neighbor_affinity_weights_top_assert.svh"

  `PNAW_ASSERT_NEXT(a_busy_after_item, in_chan.valid && in_chan.ready && !skip, !in_chan.ready, "item taken while busy")
  `PNAW_ASSERT_NOW(a_no_overflow, wres_valid, !fifo_full, "weight pushed into full queue")
  `PNAW_ASSERT_NOW(a_issue_has_room, $rose(cmd.issue), $past(room), "issue without queue room")

endmodule

[hw/rtl/pnaw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnaw_ctrl
// Sequencer: item accept, line buffer reads, weight issue per direction.
// ----------------------------------------------------------------------------
module pnaw_ctrl import pnaw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] dir_r, dir_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dir_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.dir   = dir_t'(dir_r);
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && !st.skip) state_nxt = ST_RD0;
      end
      ST_RD0: begin
        cmd.rd_sel = RD_CENTER;
        state_nxt  = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_sel = RD_SIDE;
        cmd.cap0   = 1'b1;
        cmd.wr     = 1'b1;
        state_nxt  = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_sel = RD_LEFT;
        cmd.cap1   = 1'b1;
        state_nxt  = ST_RD3;
      end
      ST_RD3: begin
        cmd.cap2  = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (st.room) begin
          state_nxt = ST_ISSUE;
          dir_nxt   = 2'd0;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        dir_nxt   = dir_r + 2'd1;
        if (dir_t'(dir_r) == DIR_LEFT) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/pnaw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnaw_dp
// Config registers, frame counters, line buffers and neighbor selection.
// ----------------------------------------------------------------------------
module pnaw_dp import pnaw_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output logic                  skip,
  input  logic                  in_mode,
  input  logic [CH_W-1:0]       in_red,
  input  logic [CH_W-1:0]       in_green,
  input  logic [CH_W-1:0]       in_blue,
  input  logic [CH_W-1:0]       in_edge,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [SIG_W-1:0]      inv_sig_color,
  output logic [SIG_W-1:0]      inv_sig_edge,
  output logic                  op_valid,
  output logic [COLOR_W-1:0]    op_ca,
  output logic [COLOR_W-1:0]    op_cb,
  output logic [CH_W-1:0]       op_edge,
  output meta_t                 op_meta
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [DIM_CFG_W-1:0] width_r, height_r;
  logic [SIG_W-1:0]     isc_r, ise_r;
  logic [CW-1:0]        col_cnt_r;
  logic [RW-1:0]        row_cnt_r;

  logic [WW-1:0] dim_w;
  logic [RW-1:0] dim_h;
  logic [CW-1:0] col;
  logic [RW-1:0] cr;
  logic          frame_done;
  logic [RW+WW-1:0] row_base;
  logic [IDX_W-1:0] cidx;
  logic [NDIR-1:0]  mask;
  logic             has_right;

  logic               flush_r;
  logic [COLOR_W-1:0] cur_r;
  logic [CH_W-1:0]    edge_r;
  logic [CW-1:0]      col_r;
  logic [IDX_W-1:0]   cidx_r;
  logic [NDIR-1:0]    mask_r;

  logic [COLOR_W-1:0] newer_mem [MAX_WIDTH];
  logic [COLOR_W-1:0] older_mem [MAX_WIDTH];
  logic [CH_W-1:0]    edge_mem  [MAX_WIDTH];
  logic [CW-1:0]      naddr, oaddr;
  logic [COLOR_W-1:0] nrd_r, ord_r;
  logic [CH_W-1:0]    erd_r;

  logic [COLOR_W-1:0] cc_r, oc_r, rc_r, lo_r, ln_r;
  logic [CH_W-1:0]    ce_r;
  dir_t               last_dir;
  logic [IDX_W-1:0]   w_ext;

  assign inv_sig_color = isc_r;
  assign inv_sig_edge  = ise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_CFG_W'(640);
      height_r <= DIM_CFG_W'(480);
      isc_r    <= SIG_W'(256);
      ise_r    <= SIG_W'(256);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_WIDTH:         width_r  <= cfg_wdata[DIM_CFG_W-1:0];
        REG_HEIGHT:        height_r <= cfg_wdata[DIM_CFG_W-1:0];
        REG_INV_SIG_COLOR: isc_r    <= cfg_wdata[SIG_W-1:0];
        REG_INV_SIG_EDGE:  ise_r    <= cfg_wdata[SIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < DIM_CFG_W'(2))             dim_w = WW'(2);
    else if (32'(width_r) > MAX_WIDTH)       dim_w = WW'(MAX_WIDTH);
    else                                     dim_w = WW'(width_r);
    if (height_r < DIM_CFG_W'(2))            dim_h = RW'(2);
    else if (32'(height_r) > MAX_HEIGHT)     dim_h = RW'(MAX_HEIGHT);
    else                                     dim_h = RW'(height_r);
  end

  always_comb begin
    if (32'(col_cnt_r) >= 32'(dim_w)) col = CW'(dim_w - WW'(1));
    else                              col = col_cnt_r;
    frame_done = row_cnt_r >= dim_h;
    skip       = in_mode != frame_done;
    cr         = in_mode ? dim_h - RW'(1) : row_cnt_r - RW'(1);
    row_base   = (RW+WW)'(cr) * (RW+WW)'(dim_w);
    cidx       = IDX_W'(row_base) + IDX_W'(col);
    has_right  = (32'(col) + 1) < 32'(dim_w);
    mask[DIR_DOWN]  = !in_mode;
    mask[DIR_UP]    = cr != '0;
    mask[DIR_RIGHT] = has_right;
    mask[DIR_LEFT]  = col != '0;
    if (!(in_mode || row_cnt_r != '0)) mask = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cmd.accept && !skip) begin
      if (!has_right) begin
        col_cnt_r <= '0;
        row_cnt_r <= in_mode ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_r <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !skip) begin
      flush_r <= in_mode;
      cur_r   <= {in_red, in_green, in_blue};
      edge_r  <= in_edge;
      col_r   <= col;
      cidx_r  <= cidx;
      mask_r  <= mask;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_CENTER: naddr = col_r;
      RD_SIDE:   naddr = col_r + CW'(1);
      RD_LEFT:   naddr = col_r - CW'(1);
      default:   naddr = col_r;
    endcase
    oaddr = (cmd.rd_sel == RD_SIDE) ? col_r - CW'(1) : col_r;
  end

  always_ff @(posedge clk) begin
    nrd_r <= newer_mem[naddr];
    ord_r <= older_mem[oaddr];
    erd_r <= edge_mem[col_r];
    if (cmd.wr && !flush_r) begin
      older_mem[col_r] <= nrd_r;
      newer_mem[col_r] <= cur_r;
      edge_mem[col_r]  <= edge_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap0) begin
      cc_r <= nrd_r;
      oc_r <= ord_r;
      ce_r <= erd_r;
    end
    if (cmd.cap1) begin
      rc_r <= nrd_r;
      lo_r <= ord_r;
    end
    if (cmd.cap2) ln_r <= nrd_r;
  end

  always_comb begin
    last_dir = DIR_DOWN;
    if (mask_r[DIR_UP])    last_dir = DIR_UP;
    if (mask_r[DIR_RIGHT]) last_dir = DIR_RIGHT;
    if (mask_r[DIR_LEFT])  last_dir = DIR_LEFT;
  end

  assign w_ext = IDX_W'(dim_w);

  always_comb begin
    op_valid     = cmd.issue && mask_r[cmd.dir];
    op_ca        = cc_r;
    op_edge      = ce_r;
    op_meta.cidx = cidx_r;
    op_meta.dir  = cmd.dir;
    op_meta.last = cmd.dir == last_dir;
    case (cmd.dir)
      DIR_DOWN: begin
        op_cb        = cur_r;
        op_meta.nidx = cidx_r + w_ext;
      end
      DIR_UP: begin
        op_cb        = oc_r;
        op_meta.nidx = cidx_r - w_ext;
      end
      DIR_RIGHT: begin
        op_cb        = rc_r;
        op_meta.nidx = cidx_r + IDX_W'(1);
      end
      default: begin
        op_cb        = flush_r ? ln_r : lo_r;
        op_meta.nidx = cidx_r - IDX_W'(1);
      end
    endcase
  end

endmodule

[hw/rtl/pnaw_wunit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnaw_wunit
// Pipelined Gaussian affinity: squared distances, scaling, table exp.
// ----------------------------------------------------------------------------
module pnaw_wunit import pnaw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SIG_W-1:0]   inv_sig_color,
  input  logic [SIG_W-1:0]   inv_sig_edge,
  input  logic               op_valid,
  input  logic [COLOR_W-1:0] op_ca,
  input  logic [COLOR_W-1:0] op_cb,
  input  logic [CH_W-1:0]    op_edge,
  input  meta_t              op_meta,
  output logic               res_valid,
  output res_t               res
);

  logic [WU_STAGES-1:0] v_r;
  meta_t                meta_r [WU_STAGES];

  logic signed [8:0]  dr, dg, db;
  logic signed [17:0] sr, sg, sb;
  logic [17:0] d2_r;
  logic [15:0] e2_r;
  logic [41:0] xc_r;
  logic [39:0] xe_r;
  logic [42:0] x_r;
  logic        z4_r, z5_r, z6_r, z7_r, z8_r;
  logic [24:0] it4_r, ft4_r, it5_r, ft5_r, it6_r, ft6_r;
  logic [19:0] r4_r, r5_r, r6_r;
  logic [39:0] rr4_r;
  logic [14:0] t2_5_r, t2_6_r;
  logic [34:0] t2r5_r;
  logic [26:0] q6_r;
  logic [24:0] res7_r, p7_r;
  logic [49:0] pp, wp;
  logic [25:0] w8_r;
  logic [26:0] rnd;
  logic [18:0] rs;
  logic [WGT_W-1:0] wgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[WU_STAGES-2:0], op_valid};
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= op_meta;
    for (int i = 1; i < WU_STAGES; i++) meta_r[i] <= meta_r[i-1];
  end

  always_comb begin
    dr = $signed({1'b0, op_ca[23:16]}) - $signed({1'b0, op_cb[23:16]});
    dg = $signed({1'b0, op_ca[15:8]})  - $signed({1'b0, op_cb[15:8]});
    db = $signed({1'b0, op_ca[7:0]})   - $signed({1'b0, op_cb[7:0]});
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    pp = 50'(it6_r) * 50'(ft6_r);
    wp = 50'(p7_r) * 50'(res7_r);
    rnd = 27'(w8_r) + 27'd128;
    rs  = rnd[26:8];
  end

  always_ff @(posedge clk) begin
    d2_r   <= 18'(sr[15:0]) + 18'(sg[15:0]) + 18'(sb[15:0]);
    e2_r   <= 16'(op_edge) * 16'(op_edge);
    xc_r   <= 42'(d2_r) * 42'(inv_sig_color);
    xe_r   <= 40'(e2_r) * 40'(inv_sig_edge);
    x_r    <= 43'(xc_r) + 43'(xe_r);
    z4_r   <= (x_r[42:28] != '0) || (x_r[27:24] >= 4'd12);
    it4_r  <= exp_int(x_r[27:24]);
    ft4_r  <= exp_frac(x_r[23:20]);
    r4_r   <= x_r[19:0];
    rr4_r  <= 40'(x_r[19:0]) * 40'(x_r[19:0]);
    t2_5_r <= rr4_r[39:25];
    t2r5_r <= 35'(rr4_r[39:25]) * 35'(r4_r);
    r5_r   <= r4_r;
    it5_r  <= it4_r;
    ft5_r  <= ft4_r;
    z5_r   <= z4_r;
    q6_r   <= 27'(t2r5_r[34:24]) * 27'(17'd43691);
    t2_6_r <= t2_5_r;
    r6_r   <= r5_r;
    it6_r  <= it5_r;
    ft6_r  <= ft5_r;
    z6_r   <= z5_r;
    res7_r <= 25'(1 << 24) - 25'(r6_r) + 25'(t2_6_r) - 25'(q6_r[26:17]);
    p7_r   <= pp[48:24];
    z7_r   <= z6_r;
    w8_r   <= wp[49:24];
    z8_r   <= z7_r;
    if (z8_r)                 wgt_r <= '0;
    else if (rs > 19'd65535)  wgt_r <= '1;
    else                      wgt_r <= rs[WGT_W-1:0];
  end

  assign res_valid  = v_r[WU_STAGES-1];
  assign res.meta   = meta_r[WU_STAGES-1];
  assign res.weight = wgt_r;

endmodule

[hw/rtl/pnaw_ofifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnaw_ofifo
// Output item queue with credit count covering items still in the pipeline.
// ----------------------------------------------------------------------------
module pnaw_ofifo import pnaw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic reserve,
  input  logic push,
  input  res_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output res_t pop_data,
  output logic room,
  output logic full
);

  res_t                mem_r [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wp_r, rp_r;
  logic [OFIFO_CW-1:0] cnt_r, credit_r;
  logic                pop;

  assign pop_valid = cnt_r != '0;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rp_r];
  assign full      = cnt_r == OFIFO_CW'(OFIFO_DEPTH);
  assign room      = credit_r <= OFIFO_CW'(OFIFO_DEPTH - NDIR);

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
      credit_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + OFIFO_AW'(1);
      if (pop)  rp_r <= rp_r + OFIFO_AW'(1);
      cnt_r    <= cnt_r + OFIFO_CW'(push) - OFIFO_CW'(pop);
      credit_r <= credit_r + OFIFO_CW'(reserve) - OFIFO_CW'(pop);
    end
  end

endmodule

[sim/tb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checker
// Watches the pixel, weight and register channels of the affinity block. It
// keeps its own line buffers, counters and registers, predicts the weight
// items of every accepted pixel item and compares them in order.
// ----------------------------------------------------------------------------
module tb_checker import pnaw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pnaw_in_if   in_mon,
  pnaw_out_if  out_mon,
  pnaw_cfg_if  cfg_mon,
  output int   errors,
  output int   pending,
  output int   n_weights
);

  typedef struct {
    logic [IDX_W-1:0] cidx;
    logic [IDX_W-1:0] nidx;
    dir_t             dir;
    logic [WGT_W-1:0] wgt;
    logic             last;
  } weight_item_t;

  localparam longint unsigned EXP_K [12] = '{
    16777216, 6171993, 2270549, 835288, 307285, 113044,
    41587, 15299, 5628, 2070, 762, 280
  };
  localparam longint unsigned EXP_J [16] = '{
    16777216, 15760736, 14805841, 13908801, 13066109, 12274473,
    11530801, 10832185, 10175896, 9559370, 8980197, 8436114,
    7924996, 7444844, 6993783, 6570052
  };

  weight_item_t     weight_q [$];
  logic [23:0]      row_new_rgb [1024];
  logic [23:0]      row_old_rgb [1024];
  logic [7:0]       row_new_edge [1024];
  int               col_cnt;
  int               row_cnt;
  logic [10:0]      width_reg;
  logic [10:0]      height_reg;
  logic [23:0]      sig_color;
  logic [23:0]      sig_edge;

  function automatic int clamp_dim(logic [10:0] v);
    if (v < 2) return 2;
    if (v > 1024) return 1024;
    return int'(v);
  endfunction

  function automatic logic [WGT_W-1:0] affinity(logic [23:0] ca, logic [23:0] cb,
                                                logic [7:0] e);
    int dr, dg, db;
    longint unsigned d2, e2, x, k, j, r, t2, t3, res, p, w;
    dr = int'(ca[23:16]) - int'(cb[23:16]);
    dg = int'(ca[15:8]) - int'(cb[15:8]);
    db = int'(ca[7:0]) - int'(cb[7:0]);
    d2 = longint'(dr * dr + dg * dg + db * db);
    e2 = longint'(e) * longint'(e);
    x = d2 * sig_color + e2 * sig_edge;
    k = x >> 24;
    if (k >= 12) return '0;
    j = (x >> 20) & 64'hF;
    r = x & 64'hFFFFF;
    t2 = (r * r) >> 25;
    t3 = ((t2 * r) >> 24) / 3;
    res = 64'd16777216 - r + t2 - t3;
    p = (EXP_K[k] * EXP_J[j]) >> 24;
    w = (((p * res) >> 24) + 128) >> 8;
    return (w > 65535) ? 16'hFFFF : w[15:0];
  endfunction

  task automatic add_weight(int cidx, int nidx, dir_t d, logic [23:0] cc,
                            logic [23:0] nc, logic [7:0] ce, logic lst);
    weight_item_t it;
    it.cidx = cidx[IDX_W-1:0];
    it.nidx = nidx[IDX_W-1:0];
    it.dir  = d;
    it.wgt  = affinity(cc, nc, ce);
    it.last = lst;
    weight_q.insert(weight_q.size(), it);
  endtask

  task automatic predict_item(logic flush, logic [23:0] cur, logic [7:0] ein);
    int w, h, col, row, cr, cidx;
    logic [23:0] cc;
    logic [7:0] ce;
    logic has_dn, has_up, has_rt, has_lt;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    col = (col_cnt >= w) ? w - 1 : col_cnt;
    row = row_cnt;
    if (flush != (row >= h)) return;
    cr = flush ? h - 1 : row - 1;
    cc = row_new_rgb[col];
    ce = row_new_edge[col];
    cidx = cr * w + col;
    if (flush || row >= 1) begin
      has_dn = !flush;
      has_up = cr > 0;
      has_rt = col + 1 < w;
      has_lt = col > 0;
      if (has_dn)
        add_weight(cidx, cidx + w, DIR_DOWN, cc, cur, ce, !(has_up || has_rt || has_lt));
      if (has_up)
        add_weight(cidx, cidx - w, DIR_UP, cc, row_old_rgb[col], ce, !(has_rt || has_lt));
      if (has_rt)
        add_weight(cidx, cidx + 1, DIR_RIGHT, cc, row_new_rgb[col + 1], ce, !has_lt);
      if (has_lt)
        add_weight(cidx, cidx - 1, DIR_LEFT, cc,
                   flush ? row_new_rgb[col - 1] : row_old_rgb[col - 1], ce, 1'b1);
    end
    if (!flush) begin
      row_old_rgb[col]  = row_new_rgb[col];
      row_new_rgb[col]  = cur;
      row_new_edge[col] = ein;
    end
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = flush ? 0 : ((row + 1) & 11'h7FF);
    end else begin
      col_cnt = col + 1;
    end
  endtask

  task automatic check_weight();
    weight_item_t e;
    n_weights++;
    if (weight_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("tb_checker: unexpected weight item c=%0d n=%0d dir=%0d w=%0d",
                 out_mon.center_index, out_mon.neighbor_index, out_mon.direction,
                 out_mon.weight);
      return;
    end
    e = weight_q.pop_front();
    if (out_mon.center_index !== e.cidx || out_mon.neighbor_index !== e.nidx ||
        out_mon.direction !== e.dir || out_mon.weight !== e.wgt ||
        out_mon.last !== e.last) begin
      errors++;
      if (errors <= 10)
        $display("tb_checker: mismatch exp c=%0d n=%0d d=%0d w=%0d l=%0d got c=%0d n=%0d d=%0d w=%0d l=%0d",
                 e.cidx, e.nidx, e.dir, e.wgt, e.last,
                 out_mon.center_index, out_mon.neighbor_index, out_mon.direction,
                 out_mon.weight, out_mon.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  <= 11'd640;
      height_reg <= 11'd480;
      sig_color  <= 24'd256;
      sig_edge   <= 24'd256;
      col_cnt    <= 0;
      row_cnt    <= 0;
      errors     = 0;
      n_weights  = 0;
      weight_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.index))
          REG_WIDTH:         width_reg  <= cfg_mon.data[10:0];
          REG_HEIGHT:        height_reg <= cfg_mon.data[10:0];
          REG_INV_SIG_COLOR: sig_color  <= cfg_mon.data;
          REG_INV_SIG_EDGE:  sig_edge   <= cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_item(in_mon.mode, {in_mon.red, in_mon.green, in_mon.blue},
                     in_mon.edge_value);
      if (out_mon.valid && out_mon.ready)
        check_weight();
    end
    pending = weight_q.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frames of pixel and flush items into the affinity block, with random
// gaps on both channels and one long output stall, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top import pnaw_pkg::*;;

  logic clk;
  logic rst_n;
  int   errors, pending, n_weights;
  int   n_items;
  int   n_frames;
  bit   no_gaps;

  pnaw_in_if  in_if ();
  pnaw_out_if out_if ();
  pnaw_cfg_if cfg_if ();

  pixel_neighbor_affinity_weights_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  tb_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .cfg_mon   (cfg_if),
    .errors    (errors),
    .pending   (pending),
    .n_weights (n_weights)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    bit hs;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do begin
      @(negedge clk);
      hs = cfg_if.ready;
      @(posedge clk);
    end while (!hs);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_item(logic m, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [7:0] e);
    int gap;
    bit hs;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.red        <= r;
    in_if.green      <= g;
    in_if.blue       <= b;
    in_if.edge_value <= e;
    do begin
      @(negedge clk);
      hs = in_if.ready;
      @(posedge clk);
    end while (!hs);
    n_items++;
  endtask

  task automatic send_junk(logic m);
    send_item(m, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_config(logic [10:0] w, logic [10:0] h, logic [23:0] sc,
                            logic [23:0] se);
    write_reg(REG_WIDTH, 24'(w));
    write_reg(REG_HEIGHT, 24'(h));
    write_reg(REG_INV_SIG_COLOR, sc);
    write_reg(REG_INV_SIG_EDGE, se);
  endtask

  // style 0 random, 1 extremes, 2 near-flat colors
  task automatic run_frame(int w, int h, int style, bit noise);
    logic [7:0] r, g, b, e;
    int k;
    for (int row = 0; row < h; row++) begin
      for (int col = 0; col < w; col++) begin
        k = row * w + col;
        case (style)
          1: begin
            r = k[0] ? 8'hFF : 8'h00;
            g = k[1] ? 8'hFF : 8'h00;
            b = k[2] ? 8'h00 : 8'hFF;
            e = k[0] ^ k[1] ? 8'hFF : 8'h00;
          end
          2: begin
            r = 8'(100 + $urandom_range(0, 6));
            g = 8'(50 + $urandom_range(0, 6));
            b = 8'(200 + $urandom_range(0, 6));
            e = 8'($urandom_range(0, 20));
          end
          default: begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); e = 8'($urandom);
          end
        endcase
        if (noise && $urandom_range(0, 15) == 0)
          send_junk(1'b1);
        send_item(1'b0, r, g, b, e);
      end
    end
    if (noise && $urandom_range(0, 2) == 0)
      send_junk(1'b0);
    for (int col = 0; col < w; col++)
      send_junk(1'b1);
    n_frames++;
    drain();
  endtask

  // output side: random stalls, plus one long hold-off to back up the block
  initial begin
    int gap;
    int cyc;
    bit held;
    out_if.ready = 1'b0;
    held = 1'b0;
    cyc = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && cyc > 3000) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        cyc += 400;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        cyc += gap;
      end
      out_if.ready <= 1'b1;
      gap = $urandom_range(1, 20);
      repeat (gap) @(posedge clk);
      cyc += gap;
    end
  end

  initial begin
    int w, h;
    logic [23:0] sc, se;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = 1'b0;
    in_if.red = '0;
    in_if.green = '0;
    in_if.blue = '0;
    in_if.edge_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_WIDTH;
    cfg_if.data = '0;
    n_items = 0;
    n_frames = 0;
    no_gaps = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: clamped tiny dims, zero and full sigmas, extreme colors
    set_config(11'd0, 11'd1, 24'd0, 24'd0);
    run_frame(2, 2, 1, 1'b1);
    set_config(11'd3, 11'd3, 24'hFFFFFF, 24'hFFFFFF);
    run_frame(3, 3, 1, 1'b0);

    n_items = 0;
    while (n_items < 500) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
      h = $urandom_range(2, 5);
      sc = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2048));
      se = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4096));
      no_gaps = ($urandom_range(0, 4) == 0);
      set_config(11'(w), 11'(h), sc, se);
      run_frame(w, h, ($urandom_range(0, 3) == 0) ? 2 : 0, 1'b1);
    end

    $display("tb_top: %0d frames, %0d random items, %0d weight items checked",
             n_frames, n_items, n_weights);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d mismatches", errors);
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pnaw_pkg.sv
hw/rtl/pnaw_ifs.sv
hw/rtl/pnaw_ctrl.sv
hw/rtl/pnaw_dp.sv
hw/rtl/pnaw_wunit.sv
hw/rtl/pnaw_ofifo.sv
hw/rtl/pixel_neighbor_affinity_weights_top.sv
sim/tb_checker.sv
sim/tb_top.sv
